FILE: sv/bdp_pkg.sv
// Shared constants and types for the button debounce / double press block.
`timescale 1ns / 1ps
`default_nettype none

package bdp_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NUM_BUTTONS    = 3;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;

  // lane order within a poll
  localparam int BTN_UP   = 0;
  localparam int BTN_DOWN = 1;
  localparam int BTN_OK   = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_WINDOW   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic up_event;
    logic down_event;
    logic ok_single;
    logic ok_double;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/bdp_in_if.sv
// Poll request channel: three button levels and the current time.
`timescale 1ns / 1ps
`default_nettype none

interface bdp_in_if #(
  parameter int TIME_WIDTH = bdp_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  up_level;
  logic                  down_level;
  logic                  ok_level;
  logic [TIME_WIDTH-1:0] now_ms;

  modport source (output valid, output up_level, output down_level, output ok_level,
                  output now_ms, input ready);
  modport sink   (input valid, input up_level, input down_level, input ok_level,
                  input now_ms, output ready);
endinterface

`default_nettype wire

FILE: sv/bdp_out_if.sv
// Result channel: button events of one poll.
`timescale 1ns / 1ps
`default_nettype none

interface bdp_out_if;
  logic valid;
  logic ready;
  logic up_event;
  logic down_event;
  logic ok_single;
  logic ok_double;

  modport source (output valid, output up_event, output down_event, output ok_single,
                  output ok_double, input ready);
  modport sink   (input valid, input up_event, input down_event, input ok_single,
                  input ok_double, output ready);
endinterface

`default_nettype wire

FILE: sv/bdp_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none

interface bdp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bdp_pkg::CFG_IDX_W-1:0]   addr;
  logic [bdp_pkg::CFG_W-1:0]       data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/bdp_lane.sv
// One button lane: edge detect and debounce against the last accepted press.
`timescale 1ns / 1ps
`default_nettype none

module bdp_lane #(
  parameter int TIME_WIDTH = bdp_pkg::TIME_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     level,
  input  logic [TIME_WIDTH-1:0]    now,
  input  logic [bdp_pkg::CFG_W-1:0] debounce,
  output logic                     press_ok
);

  logic                  prev_r;
  logic [TIME_WIDTH-1:0] accept_time_r;
  logic [TIME_WIDTH-1:0] accept_time_nxt;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  pressed;

  assign pressed  = ~level;
  // wraps modulo 2^TIME_WIDTH
  assign elapsed  = now - accept_time_r;
  assign press_ok = pressed & ~prev_r & (elapsed >= TIME_WIDTH'(debounce));
  assign accept_time_nxt = press_ok ? now : accept_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r        <= 1'b0;
      accept_time_r <= '0;
    end else if (en) begin
      prev_r        <= pressed;
      accept_time_r <= accept_time_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bdp_merge.sv
// Merge of lane results: ok double-press window and result assembly.
`timescale 1ns / 1ps
`default_nettype none

module bdp_merge #(
  parameter int TIME_WIDTH = bdp_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [bdp_pkg::NUM_BUTTONS-1:0]   press_ok,
  input  logic [TIME_WIDTH-1:0]             now,
  input  logic [bdp_pkg::CFG_W-1:0]         window,
  output bdp_pkg::result_t                  res
);

  logic                  waiting_r;
  logic                  waiting_nxt;
  logic [TIME_WIDTH-1:0] first_time_r;
  logic [TIME_WIDTH-1:0] first_time_nxt;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  in_window;
  logic                  ok_press;
  logic                  single;
  logic                  dbl;

  assign ok_press  = press_ok[bdp_pkg::BTN_OK];
  assign elapsed   = now - first_time_r;
  assign in_window = elapsed < TIME_WIDTH'(window);

  always_comb begin
    first_time_nxt = first_time_r;
    waiting_nxt    = waiting_r;
    single         = 1'b0;
    dbl            = 1'b0;
    if (ok_press) begin
      if (waiting_r && in_window) begin
        dbl         = 1'b1;
        waiting_nxt = 1'b0;
      end else begin
        // rearm; a stale pending single is dropped. A zero window expires at once.
        first_time_nxt = now;
        single         = (window == '0);
        waiting_nxt    = (window != '0);
      end
    end else if (waiting_r && !in_window) begin
      single      = 1'b1;
      waiting_nxt = 1'b0;
    end
  end

  always_comb begin
    res.up_event   = press_ok[bdp_pkg::BTN_UP];
    res.down_event = press_ok[bdp_pkg::BTN_DOWN];
    res.ok_single  = single;
    res.ok_double  = dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r    <= 1'b0;
      first_time_r <= '0;
    end else if (en) begin
      waiting_r    <= waiting_nxt;
      first_time_r <= first_time_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/button_debounce_double_press_top.sv
// Top level of the button debounce block with ok double-press detection.
`timescale 1ns / 1ps
`default_nettype none

// Takes one poll request per clock while results drain and returns exactly one
// result per poll, in the cycle after it is accepted. Three button lanes do edge
// detection and debounce in parallel and a merge stage runs the ok double-press
// window; lanes, window compare and the output register form a single stage, so
// the sustained rate is one poll per cycle, limited only by the sink taking
// results. in_bus.ready stays high while the output register is empty or being
// drained. Configuration (debounce_ms at index 0, double_window_ms at index 1) is
// written on cfg_bus, always ready outside reset; other indices are ignored.
module button_debounce_double_press_top #(
  parameter int TIME_WIDTH = bdp_pkg::TIME_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bdp_in_if.sink       in_bus,
  bdp_out_if.source    out_bus,
  bdp_cfg_if.sink      cfg_bus
);

  logic [bdp_pkg::CFG_W-1:0]       debounce_r;
  logic [bdp_pkg::CFG_W-1:0]       window_r;
  logic [bdp_pkg::NUM_BUTTONS-1:0] levels;
  logic [bdp_pkg::NUM_BUTTONS-1:0] press_ok;
  logic                            in_acc;
  logic                            cfg_acc;
  logic                            out_valid_r;
  bdp_pkg::result_t                res;
  bdp_pkg::result_t                res_r;

  assign in_bus.ready  = rst_n & (~out_valid_r | out_bus.ready);
  assign in_acc        = in_bus.valid & in_bus.ready;
  assign cfg_bus.ready = rst_n;
  assign cfg_acc       = cfg_bus.valid & cfg_bus.ready;

  assign levels[bdp_pkg::BTN_UP]   = in_bus.up_level;
  assign levels[bdp_pkg::BTN_DOWN] = in_bus.down_level;
  assign levels[bdp_pkg::BTN_OK]   = in_bus.ok_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bdp_pkg::DEBOUNCE_RST;
      window_r   <= bdp_pkg::WINDOW_RST;
    end else if (cfg_acc) begin
      if (cfg_bus.addr == bdp_pkg::REG_DEBOUNCE) begin
        debounce_r <= cfg_bus.data;
      end
      if (cfg_bus.addr == bdp_pkg::REG_WINDOW) begin
        window_r <= cfg_bus.data;
      end
    end
  end

  for (genvar g = 0; g < bdp_pkg::NUM_BUTTONS; g++) begin : g_lane
    bdp_lane #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (in_acc),
      .level    (levels[g]),
      .now      (in_bus.now_ms),
      .debounce (debounce_r),
      .press_ok (press_ok[g])
    );
  end

  bdp_merge #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (in_acc),
    .press_ok (press_ok),
    .now      (in_bus.now_ms),
    .window   (window_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.up_event   = res_r.up_event;
  assign out_bus.down_event = res_r.down_event;
  assign out_bus.ok_single  = res_r.ok_single;
  assign out_bus.ok_double  = res_r.ok_double;

endmodule

`default_nettype wire

FILE: sv/bdp_checker.sv
// Port-level checks for the button debounce block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bdp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic ok_single,
  input logic ok_double
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every accepted request yields a result on the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // an empty output stage never blocks the input side
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_ok_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(ok_single && ok_double))
    else $error("single and double reported together");

endmodule

bind button_debounce_double_press_top bdp_checker u_bdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .ok_single (out_bus.ok_single),
  .ok_double (out_bus.ok_double)
);

`default_nettype wire

FILE: tb/button_debounce_double_press_top_test.sv
// Self-checking bench for the button debounce block with ok double-press detection.
`timescale 1ns / 1ps

module button_debounce_double_press_top_test;
  import bdp_pkg::*;

  localparam int TW          = TIME_WIDTH_DEF;
  localparam int PHASES      = 7;
  localparam int PHASE_POLLS = 75;
  localparam int IDLE_PCT    = 28;
  localparam int STALL_LIMIT = 2000;

  // indices the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  localparam result_t EV_NONE   = '0;
  localparam result_t EV_UP     = '{up_event: 1'b1, default: 1'b0};
  localparam result_t EV_DOWN   = '{down_event: 1'b1, default: 1'b0};
  localparam result_t EV_SINGLE = '{ok_single: 1'b1, default: 1'b0};
  localparam result_t EV_DOUBLE = '{ok_double: 1'b1, default: 1'b0};

  typedef struct packed {
    logic          up_level;
    logic          down_level;
    logic          ok_level;
    logic [TW-1:0] now_ms;
  } poll_t;

  typedef enum logic {STEP_POLL, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    poll_t                poll;
    logic                 typed;
    result_t              want;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  bdp_in_if #(.TIME_WIDTH(TW)) in_bus ();
  bdp_out_if                   out_bus ();
  bdp_cfg_if                   cfg_bus ();

  button_debounce_double_press_top #(.TIME_WIDTH(TW)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [NUM_BUTTONS-1:0] held;
  logic [TW-1:0]          last_press [NUM_BUTTONS];
  logic [TW-1:0]          arm_time;
  logic                   armed;
  logic [CFG_W-1:0]       debounce_cur;
  logic [CFG_W-1:0]       window_cur;

  result_t events_due [$];
  step_t   plan_q [$];
  string   field_name [4] = '{"up_event", "down_event", "ok_single", "ok_double"};

  logic    row_typed;
  result_t row_want;
  logic    in_idle_on;
  logic    out_idle_on;
  int      fail_count;
  int      polls_sent;
  int      results_seen;
  int      cfg_writes;
  int      n_up, n_down, n_single, n_double;
  int      stall_cycles;

  function automatic result_t predict_events(input poll_t p);
    result_t                r;
    logic [NUM_BUTTONS-1:0] lvl;
    logic [TW-1:0]          gap;
    logic [TW-1:0]          span;
    logic                   pressed;
    r             = EV_NONE;
    lvl[BTN_UP]   = p.up_level;
    lvl[BTN_DOWN] = p.down_level;
    lvl[BTN_OK]   = p.ok_level;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      pressed = ~lvl[b];
      gap     = p.now_ms - last_press[b];
      if (pressed && !held[b] && gap >= debounce_cur) begin
        if (b == BTN_OK) begin
          span = p.now_ms - arm_time;
          if (armed && span < window_cur) begin
            r.ok_double = 1'b1;
            armed       = 1'b0;
          end else begin
            arm_time = p.now_ms;
            armed    = 1'b1;
          end
        end else if (b == BTN_UP) begin
          r.up_event = 1'b1;
        end else begin
          r.down_event = 1'b1;
        end
        last_press[b] = p.now_ms;
      end
      held[b] = pressed;
    end
    // expiry is checked after the three lanes, same poll
    span = p.now_ms - arm_time;
    if (armed && span >= window_cur) begin
      r.ok_single = 1'b1;
      armed       = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_poll(input logic up, input logic down, input logic ok,
                                   input logic [TW-1:0] now, input logic typed,
                                   input result_t want);
    step_t s;
    s.kind  = STEP_POLL;
    s.poll  = '{up, down, ok, now};
    s.typed = typed;
    s.want  = want;
    s.idx   = REG_DEBOUNCE;
    s.val   = '0;
    plan_q.push_back(s);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    step_t s;
    s.kind  = STEP_WRITE;
    s.poll  = '0;
    s.typed = 1'b0;
    s.want  = EV_NONE;
    s.idx   = idx;
    s.val   = val;
    plan_q.push_back(s);
  endfunction

  // entered and left at a falling edge
  task automatic send_poll(input poll_t p, input logic typed, input result_t want);
    while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.up_level   <= p.up_level;
    in_bus.down_level <= p.down_level;
    in_bus.ok_level   <= p.ok_level;
    in_bus.now_ms     <= p.now_ms;
    row_typed         <= typed;
    row_want          <= want;
    polls_sent++;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    @(negedge clk);
  endtask

  // registers only change once every pending request has been answered
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_bus.valid <= 1'b0;
    while (events_due.size() != 0) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_DEBOUNCE: debounce_cur = val;
      REG_WINDOW:   window_cur   = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_bus.ready <= !out_idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    poll_t   seen;
    result_t want;
    result_t got;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got = '{up_event: out_bus.up_event, down_event: out_bus.down_event,
              ok_single: out_bus.ok_single, ok_double: out_bus.ok_double};
      results_seen++;
      n_up     += got.up_event;
      n_down   += got.down_event;
      n_single += got.ok_single;
      n_double += got.ok_double;
      if (events_due.size() == 0) begin
        $error("result %b arrived with no request pending", got);
        fail_count++;
      end else begin
        want = events_due.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (got[3-f] !== want[3-f]) begin
            $error("%s: expected %b, got %b", field_name[f], want[3-f], got[3-f]);
            fail_count++;
          end
        end
      end
    end
    if (rst_n === 1'b1 && in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
      seen = '{in_bus.up_level, in_bus.down_level, in_bus.ok_level, in_bus.now_ms};
      want = predict_events(seen);
      events_due.push_back(row_typed ? row_want : want);
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("button_debounce_double_press_top_test: errors");
      $finish;
    end
  end

  initial begin
    poll_t                  p;
    logic [CFG_W-1:0]       deb;
    logic [CFG_W-1:0]       win;
    logic [TW-1:0]          clock_ms;
    logic [NUM_BUTTONS-1:0] pins;
    int                     step_max;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.up_level   = 1'b1;
    in_bus.down_level = 1'b1;
    in_bus.ok_level   = 1'b1;
    in_bus.now_ms     = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.addr      = REG_DEBOUNCE;
    cfg_bus.data      = '0;
    row_typed         = 1'b0;
    row_want          = EV_NONE;
    in_idle_on        = 1'b1;
    out_idle_on       = 1'b1;
    fail_count        = 0;
    polls_sent        = 0;
    results_seen      = 0;
    cfg_writes        = 0;
    n_up              = 0;
    n_down            = 0;
    n_single          = 0;
    n_double          = 0;
    stall_cycles      = 0;

    held         = '0;
    arm_time     = '0;
    armed        = 1'b0;
    debounce_cur = DEBOUNCE_RST;
    window_cur   = WINDOW_RST;
    for (int b = 0; b < NUM_BUTTONS; b++) last_press[b] = '0;

    // levels are active low: 0 = pressed
    add_poll(1, 1, 1, 32'd0,    1, EV_NONE);
    add_poll(0, 1, 1, 32'd10,   1, EV_NONE);      // too soon after reset
    add_poll(1, 1, 1, 32'd20,   1, EV_NONE);
    add_poll(0, 1, 1, 32'd60,   1, EV_UP);
    add_poll(0, 0, 0, 32'd100,  1, EV_DOWN);      // ok arms the window
    add_poll(1, 1, 1, 32'd110,  1, EV_NONE);
    add_poll(1, 1, 0, 32'd200,  1, EV_DOUBLE);
    add_poll(1, 1, 1, 32'd210,  1, EV_NONE);
    add_poll(1, 1, 0, 32'd260,  1, EV_NONE);
    add_poll(1, 1, 1, 32'd270,  1, EV_NONE);
    add_poll(1, 1, 1, 32'd560,  1, EV_SINGLE);    // window exactly used up
    add_poll(1, 1, 0, 32'd600,  1, EV_NONE);
    add_poll(1, 1, 1, 32'd610,  1, EV_NONE);
    add_poll(1, 1, 0, 32'd630,  1, EV_NONE);      // bounce, rejected
    add_poll(1, 1, 1, 32'd640,  1, EV_NONE);
    add_poll(1, 1, 0, 32'd1000, 1, EV_NONE);      // expired but unreported: rearms
    add_poll(1, 1, 1, 32'hFFFF_FFF0, 1, EV_SINGLE);
    add_poll(0, 1, 1, 32'hFFFF_FFFF, 1, EV_UP);
    add_poll(1, 0, 1, 32'h0000_0005, 1, EV_DOWN); // debounce across the wrap
    add_poll(1, 1, 0, 32'h0000_0010, 1, EV_NONE);
    add_poll(0, 1, 1, 32'h0000_0020, 1, EV_NONE);
    add_poll(1, 1, 0, 32'h0000_0030, 0, EV_NONE);
    add_write(REG_WINDOW, '0);
    add_write(REG_DEBOUNCE, '0);
    add_poll(1, 1, 1, 32'h0000_0100, 0, EV_NONE);
    add_poll(1, 1, 0, 32'h0000_0101, 1, EV_SINGLE); // zero window: arm and expire at once
    add_poll(1, 1, 1, 32'h0000_0101, 1, EV_NONE);
    add_poll(1, 1, 0, 32'h0000_0101, 1, EV_SINGLE);
    add_write(REG_UNUSED_A, '1);
    add_write(REG_UNUSED_B, '1);
    add_poll(0, 0, 1, 32'h0000_0101, 1, EV_UP | EV_DOWN);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == STEP_WRITE) begin
        write_reg(plan_q[i].idx, plan_q[i].val);
      end else begin
        send_poll(plan_q[i].poll, plan_q[i].typed, plan_q[i].want);
      end
    end

    pins     = '1;
    clock_ms = 32'h0000_0200;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          deb = DEBOUNCE_RST;
          win = WINDOW_RST;
        end
        1: begin
          deb = '0;
          win = '0;
        end
        2: begin
          deb = '1;
          win = '1;
        end
        3: begin
          deb = '0;
          win = '1;
        end
        4: begin
          deb = '1;
          win = '0;
        end
        5: begin
          deb = CFG_W'($urandom_range(0, 40));
          win = CFG_W'($urandom_range(0, 200));
        end
        default: begin
          deb = CFG_W'($urandom);
          win = CFG_W'($urandom);
        end
      endcase
      // one phase runs flat out on both sides
      in_idle_on  = (ph != 2);
      out_idle_on <= (ph != 2);
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_WINDOW, win);
      if (ph == 0 || ph == 5) begin
        write_reg(REG_UNUSED_A, CFG_W'($urandom));
        write_reg(REG_UNUSED_B, CFG_W'($urandom));
      end
      // time steps scaled so presses land both inside and outside the windows
      step_max = ((deb > win) ? deb : win) / 3 + 3;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if ($urandom_range(99) < 4) begin
          clock_ms = $urandom;
        end else begin
          clock_ms += $urandom_range(0, step_max);
        end
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if ($urandom_range(99) < 40) pins[b] = ~pins[b];
        end
        if ($urandom_range(99) < 8) pins = NUM_BUTTONS'($urandom);
        p = '{pins[BTN_UP], pins[BTN_DOWN], pins[BTN_OK], clock_ms};
        send_poll(p, 1'b0, EV_NONE);
      end
    end

    in_bus.valid <= 1'b0;
    while (events_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("run: %0d polls, %0d results, %0d register writes over %0d settings",
             polls_sent, results_seen, cfg_writes, PHASES + 1);
    $display("events seen: %0d up, %0d down, %0d ok single, %0d ok double",
             n_up, n_down, n_single, n_double);
    if (fail_count == 0) begin
      $display("button_debounce_double_press_top_test: clean");
    end else begin
      $display("button_debounce_double_press_top_test: errors");
    end
    $finish;
  end

endmodule
